>>> sv/shb_pkg.sv
// Shared types and constants for the spherical harmonics evaluator.
// Holds the input, result and queue word layouts; no dependencies.
package shb_pkg;

    // Input component width and output fixed-point format.
    localparam int IN_WIDTH  = 16;
    localparam int FRAC_BITS = 15;
    localparam int COEFF_W   = 16;
    localparam int INDEX_W   = 4;
    localparam int NUM_COEFF = 15;

    // Unit vector components are Q30 with sign, so 32 bits hold them.
    localparam int UNIT_W    = 32;

    // Depth of the queue between normalizer and evaluator (power of two).
    localparam int Q_DEPTH   = 2;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] dir_x;
        logic signed [IN_WIDTH-1:0] dir_y;
        logic signed [IN_WIDTH-1:0] dir_z;
    } t_dir;

    typedef struct packed {
        logic [INDEX_W-1:0]        coeff_index;
        logic signed [COEFF_W-1:0] coeff_value;
        logic                      last;
        logic                      zero_vector;
    } t_coeff;

    typedef struct packed {
        logic signed [UNIT_W-1:0] ux;
        logic signed [UNIT_W-1:0] uy;
        logic signed [UNIT_W-1:0] uz;
        logic                     zero;
    } t_unit;

endpackage

>>> sv/shb_front.sv
// Normalizer front end: takes direction words, scales them to unit length.
// Uses a shift search, a square sum, a square root and three dividers; uses shb_pkg.
module shb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  shb_pkg::t_dir    i_in_data,
    output logic             o_q_valid,
    input  logic             i_q_ready,
    output shb_pkg::t_unit   o_q_data
);

    localparam int AW = 32;
    localparam logic [AW-1:0] Q_ONE = AW'(64'd1073741824);
    localparam int IN_WIDTH_X = shb_pkg::IN_WIDTH + 1;

    typedef enum logic [6:0] {
        FS_IDLE = 7'b0000001,
        FS_NORM = 7'b0000010,
        FS_SQ   = 7'b0000100,
        FS_SQRT = 7'b0001000,
        FS_DSET = 7'b0010000,
        FS_DIV  = 7'b0100000,
        FS_PUSH = 7'b1000000
    } t_fstate;

    t_fstate             r_state;
    logic                r_ib_valid;
    shb_pkg::t_dir       r_ib;
    logic [AW-1:0]       r_a    [3];
    logic                r_neg  [3];
    logic                r_zero;
    logic [3:0]          r_cnt;
    logic [63:0]         r_sum;
    logic [33:0]         r_srem;
    logic [31:0]         r_root;
    logic [31:0]         r_drem [3];
    logic [31:0]         r_dlo  [3];

    logic [33:0]         n_srem;
    logic [31:0]         n_root;
    logic [63:0]         n_sum;
    logic [31:0]         n_drem [3];
    logic [31:0]         n_dlo  [3];

    logic signed [IN_WIDTH_X-1:0] w_c [3];
    logic [AW-1:0]       w_mag  [3];
    logic [AW-1:0]       w_or;
    logic [4:0]          w_amt;
    logic                w_can_shift;
    logic [61:0]         w_num  [3];
    logic [AW-1:0]       w_q    [3];
    logic signed [shb_pkg::UNIT_W-1:0] w_u [3];

    // The input word waits in a holding register while the engine works.
    assign o_in_ready = !r_ib_valid;

    // Sign extension and magnitudes of the held input word.
    always_comb begin
        w_c[0] = IN_WIDTH_X'(r_ib.dir_x);
        w_c[1] = IN_WIDTH_X'(r_ib.dir_y);
        w_c[2] = IN_WIDTH_X'(r_ib.dir_z);
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = w_c[i][IN_WIDTH_X-1] ? AW'(-w_c[i]) : AW'(w_c[i]);
        end
    end

    // One step of the binary shift search: 16, 8, 4, 2, then 1 places.
    always_comb begin
        w_or        = r_a[0] | r_a[1] | r_a[2];
        w_amt       = 5'd16 >> r_cnt[2:0];
        w_can_shift = (w_or >> (5'd31 - w_amt)) == '0;
    end

    // Two digits of the square root per cycle.
    always_comb begin
        logic [35:0] v_t;
        logic [35:0] v_trial;
        n_srem = r_srem;
        n_root = r_root;
        n_sum  = r_sum;
        for (int k = 0; k < 2; k++) begin
            v_t     = {n_srem, n_sum[63:62]};
            v_trial = {2'b00, n_root, 2'b01};
            if (v_t >= v_trial) begin
                n_srem = 34'(v_t - v_trial);
                n_root = {n_root[30:0], 1'b1};
            end else begin
                n_srem = v_t[33:0];
                n_root = {n_root[30:0], 1'b0};
            end
            n_sum = {n_sum[61:0], 2'b00};
        end
    end

    // Two quotient bits per cycle in each of the three dividers.
    always_comb begin
        logic [32:0] v_t;
        logic        v_qb;
        for (int i = 0; i < 3; i++) begin
            n_drem[i] = r_drem[i];
            n_dlo[i]  = r_dlo[i];
            for (int k = 0; k < 2; k++) begin
                v_t  = {n_drem[i], n_dlo[i][31]};
                v_qb = v_t >= {1'b0, r_root};
                if (v_qb) begin
                    n_drem[i] = 32'(v_t - {1'b0, r_root});
                end else begin
                    n_drem[i] = v_t[31:0];
                end
                n_dlo[i] = {n_dlo[i][30:0], v_qb};
            end
        end
    end

    // Rounded numerators and the signed, clipped unit components.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {r_a[i], 30'b0} + 62'(r_root >> 1);
            w_q[i]   = (r_dlo[i] > Q_ONE) ? Q_ONE : r_dlo[i];
            if (r_zero) begin
                w_u[i] = '0;
            end else if (r_neg[i]) begin
                w_u[i] = -signed'(w_q[i]);
            end else begin
                w_u[i] = signed'(w_q[i]);
            end
        end
    end

    assign o_q_valid     = r_state == FS_PUSH;
    assign o_q_data.ux   = w_u[0];
    assign o_q_data.uy   = w_u[1];
    assign o_q_data.uz   = w_u[2];
    assign o_q_data.zero = r_zero;

    // Control: holding register and the engine sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_IDLE;
            r_ib_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_ib_valid <= 1'b1;
            end else if (r_state == FS_IDLE && r_ib_valid) begin
                r_ib_valid <= 1'b0;
            end
            unique case (r_state)
                FS_IDLE: begin
                    r_cnt <= '0;
                    if (r_ib_valid) begin
                        if (w_mag[0] == '0 && w_mag[1] == '0 && w_mag[2] == '0) begin
                            r_state <= FS_PUSH;
                        end else begin
                            r_state <= FS_NORM;
                        end
                    end
                end
                FS_NORM: begin
                    if (r_cnt == 4'd4) begin
                        r_cnt   <= '0;
                        r_state <= FS_SQ;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                FS_SQ: begin
                    if (r_cnt == 4'd2) begin
                        r_cnt   <= '0;
                        r_state <= FS_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                FS_SQRT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= FS_DSET;
                    end
                end
                FS_DSET: begin
                    r_cnt   <= '0;
                    r_state <= FS_DIV;
                end
                FS_DIV: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= FS_PUSH;
                    end
                end
                FS_PUSH: begin
                    if (i_q_ready) begin
                        r_state <= FS_IDLE;
                    end
                end
                default: r_state <= FS_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ib <= i_in_data;
        end
        unique case (r_state)
            FS_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_a[i]   <= w_mag[i];
                    r_neg[i] <= w_c[i][IN_WIDTH_X-1];
                end
                r_zero <= w_mag[0] == '0 && w_mag[1] == '0 && w_mag[2] == '0;
                r_sum  <= '0;
            end
            FS_NORM: begin
                if (w_can_shift) begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i] <= r_a[i] << w_amt;
                    end
                end
                r_srem <= '0;
                r_root <= '0;
            end
            FS_SQ: begin
                r_sum <= r_sum + 64'(r_a[r_cnt[1:0]]) * 64'(r_a[r_cnt[1:0]]);
            end
            FS_SQRT: begin
                r_srem <= n_srem;
                r_root <= n_root;
                r_sum  <= n_sum;
            end
            FS_DSET: begin
                for (int i = 0; i < 3; i++) begin
                    r_drem[i] <= 32'(w_num[i][61:32]);
                    r_dlo[i]  <= w_num[i][31:0];
                end
            end
            FS_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_drem[i] <= n_drem[i];
                    r_dlo[i]  <= n_dlo[i];
                end
            end
            FS_PUSH: begin
                r_sum <= r_sum;
            end
            default: r_sum <= r_sum;
        endcase
    end

endmodule

>>> sv/shb_queue.sv
// Short queue of unit vectors between the normalizer and the evaluator.
// Register-based, depth from shb_pkg::Q_DEPTH (a power of two); uses shb_pkg.
module shb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  shb_pkg::t_unit i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output shb_pkg::t_unit o_pop_data
);

    localparam int DEPTH = shb_pkg::Q_DEPTH;
    localparam int QAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    shb_pkg::t_unit r_mem [DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = r_cnt != (QAW+1)'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (QAW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (QAW+1)'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

>>> sv/shb_back.sv
// Evaluator back end: runs a fixed 32-step program on one shared multiplier.
// Emits the fifteen coefficients in order through an output register; uses shb_pkg.
module shb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  shb_pkg::t_unit  i_q_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output shb_pkg::t_coeff o_out_data
);

    localparam int OPW       = 40;
    localparam int MAGW      = 34;
    localparam int PRODW     = 2 * MAGW;
    localparam int RNDW      = PRODW - 30;
    localparam int NUM_STEP  = 32;
    localparam int STEP_W    = $clog2(NUM_STEP);
    localparam int COEFF_W   = shb_pkg::COEFF_W;
    localparam int OUT_SHIFT = 30 - shb_pkg::FRAC_BITS;
    localparam logic [RNDW-1:0]  OUT_HALF  = RNDW'((64'd1 << OUT_SHIFT) >> 1);
    localparam logic [RNDW-1:0]  COEFF_LIM = RNDW'(64'd1 << (COEFF_W - 1));
    localparam logic [PRODW-1:0] PROD_HALF = PRODW'(64'd536870912);
    localparam logic signed [OPW-1:0] Q_ONE = OPW'(64'd1073741824);
    localparam logic [shb_pkg::INDEX_W-1:0] LAST_IDX =
        shb_pkg::INDEX_W'(shb_pkg::NUM_COEFF - 1);

    // Harmonic constants in Q30, rounded from nine decimals.
    localparam logic [63:0] KC_0  = (64'd282094792  * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_1  = (64'd1092548431 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_2  = (64'd315391565  * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_3  = (64'd546274215  * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_4  = (64'd2503342942 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_5  = (64'd1770130770 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_6  = (64'd946174696  * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_7  = (64'd669046544  * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_8  = (64'd105785547  * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_9  = (64'd473087348  * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KC_10 = (64'd625835735  * 64'd1073741824 + 64'd500000000) / 64'd1000000000;

    typedef enum logic [5:0] {
        OP_X, OP_Y, OP_Z, OP_X2, OP_Y2, OP_Z2, OP_XY, OP_YZ, OP_XZ,
        OP_DXY, OP_T3Z, OP_T3X, OP_T7A, OP_T7B, OP_TX3Y,
        OP_I6, OP_I7, OP_I8, OP_I9, OP_I11, OP_I12, OP_I13, OP_P10, OP_P14,
        OP_K0, OP_K1, OP_K2, OP_K3, OP_K4, OP_K5, OP_K6, OP_K7, OP_K8, OP_K9, OP_K10,
        OP_ONE
    } t_op;

    typedef enum logic [4:0] {
        DST_NONE, DST_X2, DST_Y2, DST_Z2, DST_XY, DST_YZ, DST_XZ,
        DST_I6, DST_I7, DST_I8, DST_I9, DST_I11, DST_I12, DST_I13,
        DST_Z4, DST_X4, DST_X2Y2, DST_Y4
    } t_dst;

    localparam int NUM_OP  = 2 ** $bits(t_op);
    localparam int NUM_DST = 18;

    typedef struct packed {
        t_op                         a;
        t_op                         b;
        logic                        neg;
        t_dst                        dst;
        logic                        emit;
        logic [shb_pkg::INDEX_W-1:0] cidx;
    } t_step;

    function automatic t_step mk(input t_op a, input t_op b, input logic neg,
                                 input t_dst dst, input logic emit,
                                 input logic [shb_pkg::INDEX_W-1:0] cidx);
        t_step s;
        s.a    = a;
        s.b    = b;
        s.neg  = neg;
        s.dst  = dst;
        s.emit = emit;
        s.cidx = cidx;
        return s;
    endfunction

    // Program: products first, each result read no sooner than two steps later.
    function automatic t_step step_rom(input logic [STEP_W-1:0] idx);
        t_step s;
        unique case (idx)
            5'd0:  s = mk(OP_X,   OP_X,    1'b0, DST_X2,   1'b0, 4'd0);
            5'd1:  s = mk(OP_Y,   OP_Y,    1'b0, DST_Y2,   1'b0, 4'd0);
            5'd2:  s = mk(OP_Z,   OP_Z,    1'b0, DST_Z2,   1'b0, 4'd0);
            5'd3:  s = mk(OP_X,   OP_Y,    1'b0, DST_XY,   1'b0, 4'd0);
            5'd4:  s = mk(OP_Y,   OP_Z,    1'b0, DST_YZ,   1'b0, 4'd0);
            5'd5:  s = mk(OP_X,   OP_Z,    1'b0, DST_XZ,   1'b0, 4'd0);
            5'd6:  s = mk(OP_K0,  OP_ONE,  1'b0, DST_NONE, 1'b1, 4'd0);
            5'd7:  s = mk(OP_K1,  OP_XY,   1'b0, DST_NONE, 1'b1, 4'd1);
            5'd8:  s = mk(OP_K1,  OP_YZ,   1'b1, DST_NONE, 1'b1, 4'd2);
            5'd9:  s = mk(OP_K2,  OP_T3Z,  1'b0, DST_NONE, 1'b1, 4'd3);
            5'd10: s = mk(OP_K1,  OP_XZ,   1'b1, DST_NONE, 1'b1, 4'd4);
            5'd11: s = mk(OP_K3,  OP_DXY,  1'b0, DST_NONE, 1'b1, 4'd5);
            5'd12: s = mk(OP_XY,  OP_DXY,  1'b0, DST_I6,   1'b0, 4'd0);
            5'd13: s = mk(OP_YZ,  OP_T3X,  1'b0, DST_I7,   1'b0, 4'd0);
            5'd14: s = mk(OP_XY,  OP_T7A,  1'b0, DST_I8,   1'b0, 4'd0);
            5'd15: s = mk(OP_YZ,  OP_T7B,  1'b0, DST_I9,   1'b0, 4'd0);
            5'd16: s = mk(OP_XZ,  OP_T7B,  1'b0, DST_I11,  1'b0, 4'd0);
            5'd17: s = mk(OP_DXY, OP_T7A,  1'b0, DST_I12,  1'b0, 4'd0);
            5'd18: s = mk(OP_XZ,  OP_TX3Y, 1'b0, DST_I13,  1'b0, 4'd0);
            5'd19: s = mk(OP_Z2,  OP_Z2,   1'b0, DST_Z4,   1'b0, 4'd0);
            5'd20: s = mk(OP_X2,  OP_X2,   1'b0, DST_X4,   1'b0, 4'd0);
            5'd21: s = mk(OP_X2,  OP_Y2,   1'b0, DST_X2Y2, 1'b0, 4'd0);
            5'd22: s = mk(OP_Y2,  OP_Y2,   1'b0, DST_Y4,   1'b0, 4'd0);
            5'd23: s = mk(OP_K4,  OP_I6,   1'b0, DST_NONE, 1'b1, 4'd6);
            5'd24: s = mk(OP_K5,  OP_I7,   1'b1, DST_NONE, 1'b1, 4'd7);
            5'd25: s = mk(OP_K6,  OP_I8,   1'b0, DST_NONE, 1'b1, 4'd8);
            5'd26: s = mk(OP_K7,  OP_I9,   1'b1, DST_NONE, 1'b1, 4'd9);
            5'd27: s = mk(OP_K8,  OP_P10,  1'b0, DST_NONE, 1'b1, 4'd10);
            5'd28: s = mk(OP_K7,  OP_I11,  1'b1, DST_NONE, 1'b1, 4'd11);
            5'd29: s = mk(OP_K9,  OP_I12,  1'b0, DST_NONE, 1'b1, 4'd12);
            5'd30: s = mk(OP_K5,  OP_I13,  1'b1, DST_NONE, 1'b1, 4'd13);
            5'd31: s = mk(OP_K10, OP_P14,  1'b0, DST_NONE, 1'b1, 4'd14);
        endcase
        return s;
    endfunction

    logic                    r_busy;
    logic [STEP_W-1:0]       r_step;
    logic signed [OPW-1:0]   r_x;
    logic signed [OPW-1:0]   r_y;
    logic signed [OPW-1:0]   r_z;
    logic                    r_zero;
    logic signed [OPW-1:0]   r_pr [NUM_DST];

    logic                    r_s2_valid;
    logic [PRODW-1:0]        r_prod;
    logic                    r_s2_neg;
    t_dst                    r_s2_dst;
    logic                    r_s2_emit;
    logic [shb_pkg::INDEX_W-1:0] r_s2_cidx;
    logic                    r_s2_zero;

    logic                    r_out_valid;
    shb_pkg::t_coeff         r_out;

    t_step                   w_st;
    logic signed [OPW-1:0]   w_op [NUM_OP];
    logic signed [OPW-1:0]   w_a;
    logic signed [OPW-1:0]   w_b;
    logic [MAGW-1:0]         w_ma;
    logic [MAGW-1:0]         w_mb;
    logic [PRODW-1:0]        w_prod;
    logic [RNDW-1:0]         w_m;
    logic signed [OPW-1:0]   w_val;
    logic [RNDW-1:0]         w_om;
    logic signed [COEFF_W-1:0] w_coef;
    logic                    w_stall;
    logic                    w_issue;
    logic                    w_last_step;
    logic                    w_pop;

    // Operand values: unit components, stored products, their small linear combinations and the constants.
    always_comb begin
        for (int k = 0; k < NUM_OP; k++) begin
            w_op[k] = '0;
        end
        w_op[OP_X]    = r_x;
        w_op[OP_Y]    = r_y;
        w_op[OP_Z]    = r_z;
        w_op[OP_X2]   = r_pr[DST_X2];
        w_op[OP_Y2]   = r_pr[DST_Y2];
        w_op[OP_Z2]   = r_pr[DST_Z2];
        w_op[OP_XY]   = r_pr[DST_XY];
        w_op[OP_YZ]   = r_pr[DST_YZ];
        w_op[OP_XZ]   = r_pr[DST_XZ];
        w_op[OP_DXY]  = r_pr[DST_X2] - r_pr[DST_Y2];
        w_op[OP_T3Z]  = 3 * r_pr[DST_Z2] - Q_ONE;
        w_op[OP_T3X]  = 3 * r_pr[DST_X2] - r_pr[DST_Y2];
        w_op[OP_T7A]  = 7 * r_pr[DST_Z2] - Q_ONE;
        w_op[OP_T7B]  = 7 * r_pr[DST_Z2] - 3 * Q_ONE;
        w_op[OP_TX3Y] = r_pr[DST_X2] - 3 * r_pr[DST_Y2];
        w_op[OP_I6]   = r_pr[DST_I6];
        w_op[OP_I7]   = r_pr[DST_I7];
        w_op[OP_I8]   = r_pr[DST_I8];
        w_op[OP_I9]   = r_pr[DST_I9];
        w_op[OP_I11]  = r_pr[DST_I11];
        w_op[OP_I12]  = r_pr[DST_I12];
        w_op[OP_I13]  = r_pr[DST_I13];
        w_op[OP_P10]  = 35 * r_pr[DST_Z4] - 30 * r_pr[DST_Z2] + 3 * Q_ONE;
        w_op[OP_P14]  = r_pr[DST_X4] - 6 * r_pr[DST_X2Y2] + r_pr[DST_Y4];
        w_op[OP_K0]   = OPW'(KC_0);
        w_op[OP_K1]   = OPW'(KC_1);
        w_op[OP_K2]   = OPW'(KC_2);
        w_op[OP_K3]   = OPW'(KC_3);
        w_op[OP_K4]   = OPW'(KC_4);
        w_op[OP_K5]   = OPW'(KC_5);
        w_op[OP_K6]   = OPW'(KC_6);
        w_op[OP_K7]   = OPW'(KC_7);
        w_op[OP_K8]   = OPW'(KC_8);
        w_op[OP_K9]   = OPW'(KC_9);
        w_op[OP_K10]  = OPW'(KC_10);
        w_op[OP_ONE]  = Q_ONE;
    end

    // Issue stage: pick operands and multiply magnitudes.
    always_comb begin
        w_st   = step_rom(r_step);
        w_a    = w_op[w_st.a];
        w_b    = w_op[w_st.b];
        w_ma   = w_a[OPW-1] ? MAGW'(-w_a) : MAGW'(w_a);
        w_mb   = w_b[OPW-1] ? MAGW'(-w_b) : MAGW'(w_b);
        w_prod = PRODW'(w_ma) * PRODW'(w_mb);
    end

    // Result stage: round back to Q30, then round and saturate the output.
    always_comb begin
        w_m   = RNDW'((r_prod + PROD_HALF) >> 30);
        w_val = r_s2_neg ? -OPW'(w_m) : OPW'(w_m);
        w_om  = (w_m + OUT_HALF) >> OUT_SHIFT;
        if (r_s2_zero && r_s2_cidx != '0) begin
            w_coef = '0;
        end else if (r_s2_neg) begin
            w_coef = (w_om >= COEFF_LIM) ? {1'b1, {(COEFF_W-1){1'b0}}}
                                         : -COEFF_W'(w_om);
        end else begin
            w_coef = (w_om >= COEFF_LIM - RNDW'(1)) ? {1'b0, {(COEFF_W-1){1'b1}}}
                                                    : COEFF_W'(w_om);
        end
    end

    // The whole program freezes while a result waits on a full output word.
    assign w_stall     = r_s2_valid && r_s2_emit && r_out_valid && !i_out_ready;
    assign w_issue     = r_busy && !w_stall;
    assign w_last_step = r_step == STEP_W'(NUM_STEP - 1);
    assign o_q_ready   = !r_busy || (w_issue && w_last_step);
    assign w_pop       = i_q_valid && o_q_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!w_stall) begin
                r_s2_valid <= w_issue;
            end
            if (w_issue) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (w_pop) begin
                r_busy <= 1'b1;
            end else if (w_issue && w_last_step) begin
                r_busy <= 1'b0;
            end
            if (r_s2_valid && r_s2_emit && !w_stall) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_x    <= OPW'(i_q_data.ux);
            r_y    <= OPW'(i_q_data.uy);
            r_z    <= OPW'(i_q_data.uz);
            r_zero <= i_q_data.zero;
        end
        if (w_issue) begin
            r_prod    <= w_prod;
            r_s2_neg  <= w_a[OPW-1] ^ w_b[OPW-1] ^ w_st.neg;
            r_s2_dst  <= w_st.dst;
            r_s2_emit <= w_st.emit;
            r_s2_cidx <= w_st.cidx;
            r_s2_zero <= r_zero;
        end
        if (r_s2_valid && !w_stall && r_s2_dst != DST_NONE) begin
            r_pr[r_s2_dst] <= w_val;
        end
        if (r_s2_valid && r_s2_emit && !w_stall) begin
            r_out.coeff_index <= r_s2_cidx;
            r_out.coeff_value <= w_coef;
            r_out.last        <= r_s2_cidx == LAST_IDX;
            r_out.zero_vector <= r_s2_zero;
        end
    end

endmodule

>>> sv/real_sh_bands_024_eval_core.sv
// Top level of the real spherical harmonics evaluator, bands 0, 2 and 4.
// Instantiates shb_front, shb_queue and shb_back; uses shb_pkg.
//
//   Channel   Handshake                       Word
//   input     i_in_valid / o_in_ready         i_in_data  (shb_pkg::t_dir)
//   output    o_out_valid / i_out_ready       o_out_data (shb_pkg::t_coeff)
//
// Each direction word gives fifteen result words, one per cycle at best.
// The sustained rate is set by the normalizer, with its 5-step shift search,
// 3 squares, square root and three dividers, which all run once per direction.
// The evaluator runs a 32-step program on one multiplier per direction.
// Reset is synchronous, active low, and clears control state only.
// A stalled output freezes the evaluator; the queue lets the normalizer go on.
module real_sh_bands_024_eval_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  shb_pkg::t_dir   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output shb_pkg::t_coeff o_out_data
);

    logic           w_fq_valid;
    logic           w_fq_ready;
    shb_pkg::t_unit w_fq_data;
    logic           w_qb_valid;
    logic           w_qb_ready;
    shb_pkg::t_unit w_qb_data;

    // Normalizer.
    shb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_fq_valid),
        .i_q_ready  (w_fq_ready),
        .o_q_data   (w_fq_data)
    );

    // Unit vector queue.
    shb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_data  (w_fq_data),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_data   (w_qb_data)
    );

    // Harmonic evaluator.
    shb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_qb_valid),
        .o_q_ready   (w_qb_ready),
        .i_q_data    (w_qb_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
